@@ hw/rtl/tilt_pkg.sv @@
// ----------------------------------------------------------------------------
// tilt_pkg
// Shared widths, register indexes, command types and the micro-op table for
// the complementary tilt filter.
// ----------------------------------------------------------------------------
package tilt_pkg;

    localparam int IN_W       = 16;
    localparam int ANG_W      = 18;
    localparam int RATE_W     = 17;
    localparam int STEP_W     = 16;
    localparam int WGT_W      = 17;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GYRO_WEIGHT = 1'b1;

    localparam logic [STEP_W-1:0] STEP_TIME_RST   = 16'd328;
    localparam logic [WGT_W-1:0]  GYRO_WEIGHT_RST = 17'd64225;
    localparam logic [WGT_W-1:0]  WEIGHT_ONE      = 17'd65536;

    localparam logic signed [ANG_W-1:0] ANGLE_LIMIT = 18'sd92160;

    // CORDIC x/y datapath: 17-bit operands scaled by 256, plus gain headroom
    localparam int CW = 27;

    // Shared multiplier and accumulator
    localparam int MUL_W  = 25;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = 52;
    localparam int P_W    = 33;

    // Rate scaling: n = |raw|*256 + 65, q = n / 131 by reciprocal
    localparam int               N_W         = IN_W + 9;
    localparam logic [23:0]      RECIP_131   = 24'd16393004;   // floor(2^31 / 131)
    localparam int               RECIP_SHIFT = 31;
    localparam logic [7:0]       DIV_131     = 8'd131;
    localparam logic [7:0]       RATE_RND    = 8'd65;

    localparam int               SEQ_W    = 5;
    localparam logic [SEQ_W-1:0] SEQ_LAST = 5'd16;

    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_NX_RECIP,
        MUL_NY_RECIP,
        MUL_Q_131,
        MUL_GX_ST,
        MUL_GY_ST,
        MUL_W_PLO_P,
        MUL_W_PHI_P,
        MUL_W_SP,
        MUL_WA_AP,
        MUL_W_PLO_R,
        MUL_W_PHI_R,
        MUL_W_SR,
        MUL_WA_AR
    } mul_op_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_START,
        ACC_ADD16
    } acc_op_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_QEST,
        ACT_GX,
        ACT_GY,
        ACT_PX,
        ACT_PY,
        ACT_PITCH,
        ACT_EMIT
    } act_t;

    typedef struct packed {
        mul_op_t mul;
        acc_op_t acc;
        act_t    act;
        logic    wait_cordic;
        logic    wait_out;
    } uop_t;

    typedef struct packed {
        logic    start;
        mul_op_t mul;
        acc_op_t acc;
        act_t    act;
    } tilt_cmd_t;

    typedef struct packed {
        logic cordic_done;
        logic out_free;
    } tilt_status_t;

    // atan(2^-i) in 2^-16 degree
    function automatic logic [31:0] atan_deg16(input int idx);
        logic [31:0] t;
        case (idx)
            0:       t = 32'd2949120;
            1:       t = 32'd1740967;
            2:       t = 32'd919879;
            3:       t = 32'd466945;
            4:       t = 32'd234379;
            5:       t = 32'd117304;
            6:       t = 32'd58666;
            7:       t = 32'd29335;
            8:       t = 32'd14668;
            9:       t = 32'd7334;
            10:      t = 32'd3667;
            11:      t = 32'd1833;
            12:      t = 32'd917;
            13:      t = 32'd458;
            14:      t = 32'd229;
            15:      t = 32'd115;
            16:      t = 32'd57;
            17:      t = 32'd29;
            18:      t = 32'd14;
            19:      t = 32'd7;
            20:      t = 32'd4;
            21:      t = 32'd2;
            22:      t = 32'd1;
            default: t = 32'd0;
        endcase
        return t;
    endfunction

    // Stage angle rounded to 2^-frac degree
    function automatic logic [31:0] stage_angle(input int idx, input int frac);
        logic [31:0] t;
        int          sh;
        t  = atan_deg16(idx);
        sh = 16 - frac;
        if (sh > 0) begin
            t = (t + (32'd1 << (sh - 1))) >> sh;
        end
        return t;
    endfunction

    // Micro-op sequence: rate scaling, gyro increments, then both blends.
    // The multiplier result lands one step later, where the next op uses it.
    function automatic uop_t uop_at(input logic [SEQ_W-1:0] step);
        uop_t u;
        u = '{mul: MUL_NONE, acc: ACC_HOLD, act: ACT_NONE,
              wait_cordic: 1'b0, wait_out: 1'b0};
        unique case (step)
            5'd0:  u.mul = MUL_NX_RECIP;
            5'd1:  begin u.mul = MUL_Q_131;    u.act = ACT_QEST; end
            5'd2:  begin u.mul = MUL_NY_RECIP; u.act = ACT_GX;   end
            5'd3:  begin u.mul = MUL_Q_131;    u.act = ACT_QEST; end
            5'd4:  begin u.mul = MUL_GX_ST;    u.act = ACT_GY;   end
            5'd5:  begin u.mul = MUL_GY_ST;    u.act = ACT_PX;   end
            5'd6:  begin u.act = ACT_PY;       u.wait_cordic = 1'b1; end
            5'd7:  u.mul = MUL_W_PLO_P;
            5'd8:  begin u.mul = MUL_W_PHI_P;  u.acc = ACC_START; end
            5'd9:  begin u.mul = MUL_W_SP;     u.acc = ACC_ADD16; end
            5'd10: begin u.mul = MUL_WA_AP;    u.acc = ACC_ADD16; end
            5'd11: begin u.mul = MUL_W_PLO_R;  u.acc = ACC_ADD16; end
            5'd12: begin
                u.mul = MUL_W_PHI_R;
                u.acc = ACC_START;
                u.act = ACT_PITCH;
            end
            5'd13: begin u.mul = MUL_W_SR;     u.acc = ACC_ADD16; end
            5'd14: begin u.mul = MUL_WA_AR;    u.acc = ACC_ADD16; end
            5'd15: u.acc = ACC_ADD16;
            5'd16: begin u.act = ACT_EMIT;     u.wait_out = 1'b1; end
            default: ;
        endcase
        return u;
    endfunction

endpackage

@@ hw/rtl/tilt_cordic.sv @@
// ----------------------------------------------------------------------------
// tilt_cordic
// Iterative vectoring CORDIC, one stage per cycle: atan2(y, x) in 1/256 deg.
// ----------------------------------------------------------------------------
module tilt_cordic
    import tilt_pkg::*;
#(
    parameter int STAGES    = 16,
    parameter int FRAC_BITS = 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic signed [IN_W:0]    y_in,
    input  logic signed [IN_W:0]    x_in,
    output logic                    done,
    output logic signed [ANG_W-1:0] angle
);

    localparam int ZW    = FRAC_BITS + 10;
    localparam int CNT_W = $clog2(STAGES);
    localparam logic [CNT_W-1:0]     CNT_LAST = CNT_W'(STAGES - 1);
    localparam logic signed [ZW-1:0] Z_HALF   = ZW'(180 << FRAC_BITS);

    logic                    busy_reg, busy_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [CW-1:0]    x_reg, x_next;
    logic signed [CW-1:0]    y_reg, y_next;
    logic signed [ZW-1:0]    z_reg, z_next;
    logic signed [IN_W:0]    x_pre, y_pre;
    logic signed [ZW-1:0]    z_pre;
    logic signed [CW-1:0]    x_sh, y_sh;
    logic signed [ZW-1:0]    z_step;

    // Fold the left half-plane over by 180 degrees
    always_comb begin
        if (x_in[IN_W]) begin
            x_pre = -x_in;
            y_pre = -y_in;
            z_pre = y_in[IN_W] ? -Z_HALF : Z_HALF;
        end else begin
            x_pre = x_in;
            y_pre = y_in;
            z_pre = '0;
        end
    end

    assign x_sh   = x_reg >>> cnt_reg;
    assign y_sh   = y_reg >>> cnt_reg;
    assign z_step = ZW'(stage_angle(int'(cnt_reg), FRAC_BITS));

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = CW'(x_pre) <<< 8;
            y_next    = CW'(y_pre) <<< 8;
            z_next    = z_pre;
        end else if (busy_reg) begin
            // a zero residual leaves the vector where it is
            if (!y_reg[CW-1] && (y_reg != '0)) begin
                x_next = x_reg + y_sh;
                y_next = y_reg - x_sh;
                z_next = z_reg + z_step;
            end else if (y_reg[CW-1]) begin
                x_next = x_reg - y_sh;
                y_next = y_reg + x_sh;
                z_next = z_reg - z_step;
            end
            if (cnt_reg == CNT_LAST) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign done = !busy_reg;

    // Bring the accumulator to 1/256 degree, rounding when it holds more fraction bits
    generate
        if (FRAC_BITS > 8) begin : g_round
            localparam int SH = FRAC_BITS - 8;
            logic signed [ZW-1:0] z_rnd;
            assign z_rnd = z_reg + ZW'(1 << (SH - 1));
            assign angle = ANG_W'(z_rnd >>> SH);
        end else if (FRAC_BITS == 8) begin : g_same
            assign angle = ANG_W'(z_reg);
        end else begin : g_scale
            assign angle = ANG_W'(z_reg) <<< (8 - FRAC_BITS);
        end
    endgenerate

endmodule

@@ hw/rtl/tilt_ctrl.sv @@
// ----------------------------------------------------------------------------
// tilt_ctrl
// Sequencer: accepts a sample, then steps the datapath through the micro-op
// table, holding on CORDIC completion and on a full output register.
// ----------------------------------------------------------------------------
module tilt_ctrl
    import tilt_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  tilt_status_t status,
    output tilt_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             state_reg, state_next;
    logic [SEQ_W-1:0] step_reg, step_next;
    uop_t             uop;
    logic             stall;

    assign uop     = uop_at(step_reg);
    assign stall   = (uop.wait_cordic && !status.cordic_done) ||
                     (uop.wait_out && !status.out_free);
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd.start  = 1'b0;
        cmd.mul    = MUL_NONE;
        cmd.acc    = ACC_HOLD;
        cmd.act    = ACT_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.start  = 1'b1;
                    step_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                // hold the step while its wait condition is open
                if (!stall) begin
                    cmd.mul = uop.mul;
                    cmd.acc = uop.acc;
                    cmd.act = uop.act;
                    if (step_reg == SEQ_LAST) begin
                        state_next = ST_IDLE;
                    end else begin
                        step_next = step_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

@@ hw/rtl/tilt_dpath.sv @@
// ----------------------------------------------------------------------------
// tilt_dpath
// Sample and config registers, two CORDIC lanes, the shared multiplier with
// its accumulator, rate scaling, blend saturation and the output register.
// ----------------------------------------------------------------------------
module tilt_dpath
    import tilt_pkg::*;
#(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic signed [IN_W-1:0]   s_accel_x,
    input  logic signed [IN_W-1:0]   s_accel_y,
    input  logic signed [IN_W-1:0]   s_accel_z,
    input  logic signed [IN_W-1:0]   s_rate_x,
    input  logic signed [IN_W-1:0]   s_rate_y,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wr_data,
    input  tilt_cmd_t                cmd,
    output tilt_status_t             status,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [ANG_W-1:0]  m_pitch_angle,
    output logic signed [ANG_W-1:0]  m_roll_angle,
    output logic signed [RATE_W-1:0] m_pitch_rate,
    output logic signed [RATE_W-1:0] m_roll_rate
);

    localparam int BL_W = ACC_W - 32;
    localparam logic signed [BL_W-1:0]  BL_LIMIT  = BL_W'(ANGLE_LIMIT);
    localparam logic signed [ACC_W-1:0] ACC_ROUND = {{(ACC_W-32){1'b0}}, 1'b1, 31'd0};

    logic [STEP_W-1:0]        step_time_reg;
    logic [WGT_W-1:0]         gyro_weight_reg;
    logic signed [IN_W-1:0]   rx_reg, ry_reg;
    logic [RATE_W-1:0]        qest_reg;
    logic signed [RATE_W-1:0] gx_reg, gy_reg;
    logic signed [P_W-1:0]    px_reg, py_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ANG_W-1:0]  pitch_store_reg, roll_store_reg;
    logic                     m_valid_reg;
    logic signed [ANG_W-1:0]  m_pitch_angle_reg, m_roll_angle_reg;
    logic signed [RATE_W-1:0] m_pitch_rate_reg, m_roll_rate_reg;

    logic signed [IN_W:0]     lane_p_y, lane_p_x, lane_r_y;
    logic signed [ANG_W-1:0]  ang_p, ang_r;
    logic                     done_p, done_r;

    logic [IN_W:0]            abs_x, abs_y;
    logic [N_W-1:0]           n_x, n_y, n_sel, rem;
    logic                     raw_neg;
    logic [RATE_W-1:0]        q_fix;
    logic signed [RATE_W-1:0] rate_val;

    logic [WGT_W-1:0]         w_clamp, wa_clamp;
    logic signed [MUL_W-1:0]  w_op, wa_op, op_a, op_b;

    logic signed [ACC_W-1:0]  prod_ext, prod_sh16;
    logic signed [BL_W-1:0]   blend_raw;
    logic signed [ANG_W-1:0]  blend_q;
    logic                     out_free;

    // ---------------- CORDIC lanes ----------------
    assign lane_p_y = (IN_W+1)'(s_accel_y);
    assign lane_p_x = (IN_W+1)'(s_accel_z);
    assign lane_r_y = -((IN_W+1)'(s_accel_x));

    tilt_cordic #(
        .STAGES    (CORDIC_STAGES),
        .FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cordic_pitch (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .y_in    (lane_p_y),
        .x_in    (lane_p_x),
        .done    (done_p),
        .angle   (ang_p)
    );

    tilt_cordic #(
        .STAGES    (CORDIC_STAGES),
        .FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cordic_roll (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .y_in    (lane_r_y),
        .x_in    (lane_p_x),
        .done    (done_r),
        .angle   (ang_r)
    );

    // ---------------- rate scaling ----------------
    assign abs_x = rx_reg[IN_W-1] ? -((IN_W+1)'(rx_reg)) : (IN_W+1)'(rx_reg);
    assign abs_y = ry_reg[IN_W-1] ? -((IN_W+1)'(ry_reg)) : (IN_W+1)'(ry_reg);
    assign n_x   = N_W'({abs_x, 8'd0}) + N_W'(RATE_RND);
    assign n_y   = N_W'({abs_y, 8'd0}) + N_W'(RATE_RND);

    // Reciprocal estimate is low by at most one: fix with one compare
    assign raw_neg  = (cmd.act == ACT_GX) ? rx_reg[IN_W-1] : ry_reg[IN_W-1];
    assign n_sel    = (cmd.act == ACT_GX) ? n_x : n_y;
    assign rem      = n_sel - prod_reg[N_W-1:0];
    assign q_fix    = qest_reg + RATE_W'(rem >= N_W'(DIV_131));
    assign rate_val = raw_neg ? -$signed(q_fix) : $signed(q_fix);

    // ---------------- shared multiplier ----------------
    assign w_clamp  = (gyro_weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : gyro_weight_reg;
    assign wa_clamp = WEIGHT_ONE - w_clamp;
    assign w_op     = $signed(MUL_W'(w_clamp));
    assign wa_op    = $signed(MUL_W'(wa_clamp));

    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (cmd.mul)
            MUL_NX_RECIP: begin
                op_a = $signed(n_x);
                op_b = $signed(MUL_W'(RECIP_131));
            end
            MUL_NY_RECIP: begin
                op_a = $signed(n_y);
                op_b = $signed(MUL_W'(RECIP_131));
            end
            MUL_Q_131: begin
                op_a = $signed(MUL_W'(prod_reg[RECIP_SHIFT +: RATE_W]));
                op_b = $signed(MUL_W'(DIV_131));
            end
            MUL_GX_ST: begin
                op_a = MUL_W'(gx_reg);
                op_b = $signed(MUL_W'(step_time_reg));
            end
            MUL_GY_ST: begin
                op_a = MUL_W'(gy_reg);
                op_b = $signed(MUL_W'(step_time_reg));
            end
            MUL_W_PLO_P: begin
                op_a = w_op;
                op_b = $signed(MUL_W'(px_reg[15:0]));
            end
            MUL_W_PHI_P: begin
                op_a = w_op;
                op_b = MUL_W'(px_reg >>> 16);
            end
            MUL_W_SP: begin
                op_a = w_op;
                op_b = MUL_W'(pitch_store_reg);
            end
            MUL_WA_AP: begin
                op_a = wa_op;
                op_b = MUL_W'(ang_p);
            end
            MUL_W_PLO_R: begin
                op_a = w_op;
                op_b = $signed(MUL_W'(py_reg[15:0]));
            end
            MUL_W_PHI_R: begin
                op_a = w_op;
                op_b = MUL_W'(py_reg >>> 16);
            end
            MUL_W_SR: begin
                op_a = w_op;
                op_b = MUL_W'(roll_store_reg);
            end
            MUL_WA_AR: begin
                op_a = wa_op;
                op_b = MUL_W'(ang_r);
            end
            default: ;
        endcase
    end

    // ---------------- accumulate and saturate ----------------
    assign prod_ext  = ACC_W'(prod_reg);
    assign prod_sh16 = $signed({prod_reg[ACC_W-17:0], 16'd0});
    assign blend_raw = $signed(acc_reg[ACC_W-1:32]);

    always_comb begin
        if (blend_raw > BL_LIMIT) begin
            blend_q = ANGLE_LIMIT;
        end else if (blend_raw < -BL_LIMIT) begin
            blend_q = -ANGLE_LIMIT;
        end else begin
            blend_q = ANG_W'(blend_raw);
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    assign status.cordic_done = done_p && done_r;
    assign status.out_free    = out_free;

    // ---------------- control and state registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_time_reg   <= STEP_TIME_RST;
            gyro_weight_reg <= GYRO_WEIGHT_RST;
            pitch_store_reg <= '0;
            roll_store_reg  <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_wr_index)
                    REG_STEP_TIME:   step_time_reg   <= cfg_wr_data[STEP_W-1:0];
                    REG_GYRO_WEIGHT: gyro_weight_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cmd.act == ACT_PITCH) begin
                pitch_store_reg <= blend_q;
            end
            if (cmd.act == ACT_EMIT) begin
                roll_store_reg <= blend_q;
                m_valid_reg    <= 1'b1;
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            rx_reg <= s_rate_x;
            ry_reg <= s_rate_y;
        end
        if (cmd.mul != MUL_NONE) begin
            prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
        end
        case (cmd.acc)
            ACC_START: acc_reg <= ACC_ROUND + prod_ext;
            ACC_ADD16: acc_reg <= acc_reg + prod_sh16;
            default:   ;
        endcase
        case (cmd.act)
            ACT_QEST: qest_reg <= prod_reg[RECIP_SHIFT +: RATE_W];
            ACT_GX:   gx_reg   <= rate_val;
            ACT_GY:   gy_reg   <= rate_val;
            ACT_PX:   px_reg   <= P_W'(prod_reg);
            ACT_PY:   py_reg   <= P_W'(prod_reg);
            ACT_EMIT: begin
                m_pitch_angle_reg <= pitch_store_reg;
                m_roll_angle_reg  <= blend_q;
                m_pitch_rate_reg  <= gx_reg;
                m_roll_rate_reg   <= gy_reg;
            end
            default: ;
        endcase
    end

    assign m_valid       = m_valid_reg;
    assign m_pitch_angle = m_pitch_angle_reg;
    assign m_roll_angle  = m_roll_angle_reg;
    assign m_pitch_rate  = m_pitch_rate_reg;
    assign m_roll_rate   = m_roll_rate_reg;

endmodule

@@ hw/rtl/imu_complementary_tilt_filter_core.sv @@
// ----------------------------------------------------------------------------
// imu_complementary_tilt_filter_core
// Complementary pitch/roll filter over raw accelerometer and gyro samples.
// ----------------------------------------------------------------------------
// Each accepted sample yields one result: the accelerometer tilt angles from
// two parallel CORDIC lanes (atan2(ay, az) and atan2(-ax, az)), the gyro rates
// scaled to 1/256 deg/s, and the kept pitch and roll blended with weight
// gyro_weight and saturated at +-360 degrees. The block works on one sample
// at a time: the CORDIC lanes iterate one stage per cycle and the rate
// scaling runs alongside them on a single shared 25x25 multiplier, after
// which ten more sequencer steps form both blends. The next sample is
// accepted while a finished result still waits in the output register.
// Configuration writes take effect at once and belong between samples.
module imu_complementary_tilt_filter_core
    import tilt_pkg::*;
#(
    parameter int CORDIC_STAGES   = 16,
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [IN_W-1:0]   s_accel_x,
    input  logic signed [IN_W-1:0]   s_accel_y,
    input  logic signed [IN_W-1:0]   s_accel_z,
    input  logic signed [IN_W-1:0]   s_rate_x,
    input  logic signed [IN_W-1:0]   s_rate_y,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [ANG_W-1:0]  m_pitch_angle,
    output logic signed [ANG_W-1:0]  m_roll_angle,
    output logic signed [RATE_W-1:0] m_pitch_rate,
    output logic signed [RATE_W-1:0] m_roll_rate,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [CFG_DATA_W-1:0]    cfg_wr_data
);

    tilt_cmd_t    cmd;
    tilt_status_t status;

    tilt_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    tilt_dpath #(
        .CORDIC_STAGES   (CORDIC_STAGES),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_accel_x     (s_accel_x),
        .s_accel_y     (s_accel_y),
        .s_accel_z     (s_accel_z),
        .s_rate_x      (s_rate_x),
        .s_rate_y      (s_rate_y),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pitch_angle (m_pitch_angle),
        .m_roll_angle  (m_roll_angle),
        .m_pitch_rate  (m_pitch_rate),
        .m_roll_rate   (m_roll_rate)
    );

endmodule
